// ===== rtl/ple_pkg.sv =====
// Shared constants for the positional list engine: field widths, command and status codes.
`timescale 1ns / 1ps

package ple_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FPOS_W   = 6;
   localparam int COUNT_W  = 7;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = CMD_W;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = STATUS_W;

   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

endpackage

// ===== rtl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: command sequencer, step unit and list store.
//
//   Channel  Direction  Transfer payload
//   req_*    in         tuser: command; tdata: position, item_value
//   rsp_*    out        tuser: status;  tdata: read_value, found_position, entry_count
//
// One command is worked on at a time; req_tready is high only while the sequencer is idle.
// Insert and delete shift the entries between position and the end, and find scans from entry zero
// until a match or the end, all set by the single memory read port walking one entry
// per cycle. The result sits in an output register, so the next command is taken while it
// waits; a finished command then holds until rsp_tready frees that register.
// Reset empties the list at once; the store itself needs no clearing pass.
`timescale 1ns / 1ps

module positional_list_engine_unit #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [6:0] position, [38:7] item_value, [39] zero
   input  logic [ple_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] command
   input  logic [ple_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] read_value, [37:32] found_position, [44:38] entry_count, [47:45] zero
   output logic [ple_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [ple_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   import ple_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RDWAIT = 3'd1;
   localparam logic [2:0] ST_ISH    = 3'd2;
   localparam logic [2:0] ST_IPUT   = 3'd3;
   localparam logic [2:0] ST_DSH    = 3'd4;
   localparam logic [2:0] ST_FSCAN  = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [WW-1:0]              pos_ff, pos_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   logic [WW-1:0]              idx_ff, idx_in;
   logic [WW-1:0]              dst_ff, dst_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic [FPOS_W-1:0]          fpos_ff, fpos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [FPOS_W-1:0]          rsp_fpos_ff, rsp_fpos_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic [CMD_W-1:0]           req_cmd;
   logic [WW-1:0]              req_pos_w;
   logic signed [VALUE_W-1:0]  req_val;
   logic [WW-1:0]              count_w;
   logic [WW-1:0]              count_m1;
   logic [WW-1:0]              pos_p1;
   logic                       step_down;
   logic [WW-1:0]              idx_step;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [VALUE_W-1:0]         ram_wr_data;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [VALUE_W-1:0]         ram_rd_data;

   assign req_cmd   = req_tuser[CMD_W-1:0];
   assign req_pos_w = WW'(req_tdata[POS_W-1:0]);
   assign req_val   = $signed(req_tdata[POS_W+VALUE_W-1:POS_W]);
   assign count_w   = WW'(count_ff);
   assign count_m1  = count_w - WW'(1);
   assign pos_p1    = req_pos_w + WW'(1);

   // The walk index steps down while an insert opens a gap and up for delete and find.
   assign step_down = (state_ff == ST_ISH);
   assign idx_step  = step_down ? (idx_ff - WW'(1)) : (idx_ff + WW'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      dst_in        = dst_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      fpos_in       = fpos_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_count_in  = rsp_count_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_step[AW-1:0];
      ram_wr_en     = 1'b0;
      ram_wr_addr   = dst_ff[AW-1:0];
      ram_wr_data   = ram_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in    = req_pos_w;
               val_in    = req_val;
               status_in = STATUS_OK;
               value_in  = '0;
               fpos_in   = '0;
               state_in  = ST_FIN;
               unique case (req_cmd)
                  CMD_READ: begin
                     if (req_pos_w < count_w) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_pos_w[AW-1:0];
                        state_in    = ST_RDWAIT;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  CMD_INSERT: begin
                     if (req_pos_w > count_w) begin
                        status_in = STATUS_RANGE;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else if (req_pos_w == count_w) begin
                        state_in = ST_IPUT;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = count_m1[AW-1:0];
                        idx_in      = count_m1;
                        dst_in      = count_w;
                        state_in    = ST_ISH;
                     end
                  end
                  CMD_DELETE: begin
                     if (req_pos_w < count_w) begin
                        if (pos_p1 < count_w) begin
                           ram_rd_en   = 1'b1;
                           ram_rd_addr = pos_p1[AW-1:0];
                           idx_in      = pos_p1;
                           dst_in      = req_pos_w;
                           state_in    = ST_DSH;
                        end else begin
                           count_in = count_ff - CW'(1);
                        end
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = ST_FSCAN;
                     end else begin
                        status_in = STATUS_NOTFOUND;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            value_in = $signed(ram_rd_data);
            state_in = ST_FIN;
         end
         ST_ISH: begin
            ram_wr_en = 1'b1;
            if (idx_ff == pos_ff) begin
               state_in = ST_IPUT;
            end else begin
               ram_rd_en = 1'b1;
               dst_in    = idx_ff;
               idx_in    = idx_step;
            end
         end
         ST_IPUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = val_ff;
            count_in    = count_ff + CW'(1);
            state_in    = ST_FIN;
         end
         ST_DSH: begin
            ram_wr_en = 1'b1;
            if (idx_step < count_w) begin
               ram_rd_en = 1'b1;
               dst_in    = idx_ff;
               idx_in    = idx_step;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_FIN;
            end
         end
         ST_FSCAN: begin
            if (ram_rd_data == val_ff) begin
               fpos_in  = idx_ff[FPOS_W-1:0];
               state_in = ST_FIN;
            end else if (idx_step < count_w) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_step;
            end else begin
               status_in = STATUS_NOTFOUND;
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = value_ff;
               rsp_fpos_in   = fpos_ff;
               rsp_count_in  = count_w[COUNT_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      dst_ff        <= dst_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      fpos_ff       <= fpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {
      {(RSP_TDATA_W - VALUE_W - FPOS_W - COUNT_W){1'b0}},
      rsp_count_ff,
      rsp_fpos_ff,
      rsp_value_ff
   };

endmodule

// ===== rtl/ple_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
